// File: hdl/cau_pkg.sv
package cau_pkg;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_ADDR  = 4'd4;
  localparam logic [3:0] OP_SUBR  = 4'd5;
  localparam logic [3:0] OP_SCALE = 4'd6;
  localparam logic [3:0] OP_DIVR  = 4'd7;
  localparam logic [3:0] OP_CONJ  = 4'd8;
  localparam logic [3:0] OP_EQ    = 4'd9;

  typedef struct packed {
    logic is_div;
    logic dz;
    logic eq;
    logic ovf;
    logic neg_re;
    logic neg_im;
    logic cap_re;
    logic cap_im;
  } ctl_t;

endpackage

// File: hdl/complex_arithmetic_unit_top.sv
// Complex ALU on signed fixed point (DATA_WIDTH bits, FRAC_BITS fractional):
// add, subtract, multiply, divide, real-scalar variants, conjugate and compare,
// with saturation. Fully pipelined: one transfer per cycle in, one per cycle
// out; the divider row has DATA_WIDTH + 1 cells, each producing one quotient
// bit. A stall on the output holds the whole pipeline.
module complex_arithmetic_unit_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         operation,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               is_equal,
  output logic               overflow,
  output logic               div_by_zero
);

  localparam int W  = DATA_WIDTH;
  localparam int RW = 3 * DATA_WIDTH + FRAC_BITS + 2;
  localparam int NC = DATA_WIDTH + 1;
  localparam logic [W:0]   HALFQ = {2'b01, {(W - 1){1'b0}}};
  localparam logic [W-1:0] MAXW  = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINW  = {1'b1, {(W - 1){1'b0}}};

  function automatic logic [W:0] fin_f(input logic neg, input logic cap,
                                       input logic [W:0] q);
    logic [W:0] r;
    logic [W:0] nq;
    nq = ~q + 1'b1;
    if (cap) r = {1'b1, neg ? MINW : MAXW};
    else if (neg) r = (q > HALFQ) ? {1'b1, MINW} : {1'b0, nq[W-1:0]};
    else r = (q > HALFQ - 1'b1) ? {1'b1, MAXW} : {1'b0, q[W-1:0]};
    return r;
  endfunction

  logic adv;

  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  logic                c_valid  [NC+1];
  cau_pkg::ctl_t       c_ctl    [NC+1];
  logic signed [W-1:0] c_res_re [NC+1];
  logic signed [W-1:0] c_res_im [NC+1];
  logic [RW-1:0]       c_den    [NC+1];
  logic [RW-1:0]       c_rem_re [NC+1];
  logic [RW-1:0]       c_rem_im [NC+1];
  logic [W:0]          c_q_re   [NC+1];
  logic [W:0]          c_q_im   [NC+1];

  cau_front #(.W(W), .F(FRAC_BITS), .RW(RW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .operation (operation),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .valid     (c_valid[0]),
    .ctl       (c_ctl[0]),
    .res_re    (c_res_re[0]),
    .res_im    (c_res_im[0]),
    .den       (c_den[0]),
    .rem_re    (c_rem_re[0]),
    .rem_im    (c_rem_im[0])
  );

  assign c_q_re[0] = '0;
  assign c_q_im[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_div_cell #(.W(W), .RW(RW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .prev_valid  (c_valid[k]),
      .prev_ctl    (c_ctl[k]),
      .prev_res_re (c_res_re[k]),
      .prev_res_im (c_res_im[k]),
      .prev_den    (c_den[k]),
      .prev_rem_re (c_rem_re[k]),
      .prev_rem_im (c_rem_im[k]),
      .prev_q_re   (c_q_re[k]),
      .prev_q_im   (c_q_im[k]),
      .valid       (c_valid[k+1]),
      .ctl         (c_ctl[k+1]),
      .res_re      (c_res_re[k+1]),
      .res_im      (c_res_im[k+1]),
      .den         (c_den[k+1]),
      .rem_re      (c_rem_re[k+1]),
      .rem_im      (c_rem_im[k+1]),
      .q_re        (c_q_re[k+1]),
      .q_im        (c_q_im[k+1])
    );
  end

  cau_pkg::ctl_t       lc;
  logic [W:0]          f_re, f_im;
  logic signed [W-1:0] o_re, o_im;
  logic                o_ovf;

  assign lc   = c_ctl[NC];
  assign f_re = fin_f(lc.neg_re, lc.cap_re, c_q_re[NC]);
  assign f_im = fin_f(lc.neg_im, lc.cap_im, c_q_im[NC]);

  always_comb begin
    if (lc.is_div) begin
      o_re  = f_re[W-1:0];
      o_im  = f_im[W-1:0];
      o_ovf = f_re[W] | f_im[W];
    end else begin
      o_re  = c_res_re[NC];
      o_im  = c_res_im[NC];
      o_ovf = lc.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= c_valid[NC];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re      <= 32'(o_re);
      res_im      <= 32'(o_im);
      is_equal    <= lc.eq;
      overflow    <= o_ovf;
      div_by_zero <= lc.dz;
    end
  end

endmodule

// File: hdl/cau_front.sv
module cau_front #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int RW = 3 * 32 + 16 + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [3:0]          operation,
  input  logic signed [31:0]  a_re,
  input  logic signed [31:0]  a_im,
  input  logic signed [31:0]  b_re,
  input  logic signed [31:0]  b_im,
  output logic                valid,
  output cau_pkg::ctl_t       ctl,
  output logic signed [W-1:0] res_re,
  output logic signed [W-1:0] res_im,
  output logic [RW-1:0]       den,
  output logic [RW-1:0]       rem_re,
  output logic [RW-1:0]       rem_im
);

  localparam int XW = 2 * W + 2;
  localparam logic signed [XW-1:0] MAXX = {{(W + 3){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] MINX = {{(W + 3){1'b1}}, {(W - 1){1'b0}}};
  localparam logic [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};

  function automatic logic [W:0] sat_f(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > MAXX) r = {1'b1, MAXW};
    else if (v < MINX) r = {1'b1, MINW};
    else r = {1'b0, v[W-1:0]};
    return r;
  endfunction

  logic                  v1;
  logic [3:0]            op1;
  logic signed [W-1:0]   ar1, ai1, br1, bi1;
  logic signed [2*W-1:0] prr, pii, pri, pir, pbr, pbi;
  logic signed [W-1:0]   ar_w, ai_w, br_w, bi_w;

  assign ar_w = W'(a_re);
  assign ai_w = W'(a_im);
  assign br_w = W'(b_re);
  assign bi_w = W'(b_im);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= operation;
      ar1 <= ar_w;
      ai1 <= ai_w;
      br1 <= br_w;
      bi1 <= bi_w;
      prr <= ar_w * br_w;
      pii <= ai_w * bi_w;
      pri <= ar_w * bi_w;
      pir <= ai_w * br_w;
      pbr <= br_w * br_w;
      pbi <= bi_w * bi_w;
    end
  end

  cau_pkg::ctl_t       c_n;
  cau_pkg::ctl_t       c_f;
  logic signed [W-1:0] re_n, im_n;
  logic [XW-1:0]       den_n, mre_n, mim_n;
  logic [RW-1:0]       r0_re, r0_im, dtop;

  always_comb begin
    logic signed [XW-1:0] xar, xai, xbr, xbi, xprr, xpii, xpri, xpir, nr, ni;
    logic [W:0] sr, si;
    xar  = XW'(ar1);
    xai  = XW'(ai1);
    xbr  = XW'(br1);
    xbi  = XW'(bi1);
    xprr = XW'(prr);
    xpii = XW'(pii);
    xpri = XW'(pri);
    xpir = XW'(pir);
    nr   = '0;
    ni   = '0;
    sr   = '0;
    si   = '0;
    c_n  = '0;
    den_n = '0;
    mre_n = '0;
    mim_n = '0;
    case (op1)
      cau_pkg::OP_ADD: begin
        sr = sat_f(xar + xbr);
        si = sat_f(xai + xbi);
      end
      cau_pkg::OP_SUB: begin
        sr = sat_f(xar - xbr);
        si = sat_f(xai - xbi);
      end
      cau_pkg::OP_MUL: begin
        sr = sat_f((xprr - xpii) >>> F);
        si = sat_f((xpri + xpir) >>> F);
      end
      cau_pkg::OP_DIV: begin
        den_n = XW'(pbr) + XW'(pbi);
        nr = xprr + xpii;
        ni = xpir - xpri;
        if (den_n == '0) begin
          c_n.dz = 1'b1;
          sr = {1'b0, ar1[W-1] ? MINW : MAXW};
          si = {1'b0, ai1[W-1] ? MINW : MAXW};
        end else begin
          c_n.is_div = 1'b1;
          c_n.neg_re = nr[XW-1];
          c_n.neg_im = ni[XW-1];
          mre_n = nr[XW-1] ? XW'(-nr) : XW'(nr);
          mim_n = ni[XW-1] ? XW'(-ni) : XW'(ni);
        end
      end
      cau_pkg::OP_ADDR: begin
        sr = sat_f(xar + xbr);
        si = sat_f(xai);
      end
      cau_pkg::OP_SUBR: begin
        sr = sat_f(xar - xbr);
        si = sat_f(xai);
      end
      cau_pkg::OP_SCALE: begin
        sr = sat_f(xprr >>> F);
        si = sat_f(xpir >>> F);
      end
      cau_pkg::OP_DIVR: begin
        den_n = xbr[XW-1] ? XW'(-xbr) : XW'(xbr);
        if (den_n == '0) begin
          c_n.dz = 1'b1;
          sr = {1'b0, ar1[W-1] ? MINW : MAXW};
          si = {1'b0, ai1[W-1] ? MINW : MAXW};
        end else begin
          c_n.is_div = 1'b1;
          c_n.neg_re = ar1[W-1] ^ br1[W-1];
          c_n.neg_im = ai1[W-1] ^ br1[W-1];
          mre_n = xar[XW-1] ? XW'(-xar) : XW'(xar);
          mim_n = xai[XW-1] ? XW'(-xai) : XW'(xai);
        end
      end
      cau_pkg::OP_CONJ: begin
        sr = sat_f(xar);
        si = sat_f(-xai);
      end
      cau_pkg::OP_EQ: begin
        c_n.eq = (ar1 == br1) && (ai1 == bi1);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    c_n.ovf = sr[W] | si[W];
    re_n = sr[W-1:0];
    im_n = si[W-1:0];
  end

  assign r0_re = RW'(mre_n) << F;
  assign r0_im = RW'(mim_n) << F;
  assign dtop  = RW'(den_n) << W;

  always_comb begin
    c_f        = c_n;
    c_f.cap_re = r0_re >= (dtop << 1);
    c_f.cap_im = r0_im >= (dtop << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (adv) valid <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl        <= c_f;
      res_re     <= re_n;
      res_im     <= im_n;
      den        <= dtop;
      rem_re     <= r0_re;
      rem_im     <= r0_im;
    end
  end

endmodule

// File: hdl/cau_div_cell.sv
module cau_div_cell #(
  parameter int W  = 32,
  parameter int RW = 3 * 32 + 16 + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                prev_valid,
  input  cau_pkg::ctl_t       prev_ctl,
  input  logic signed [W-1:0] prev_res_re,
  input  logic signed [W-1:0] prev_res_im,
  input  logic [RW-1:0]       prev_den,
  input  logic [RW-1:0]       prev_rem_re,
  input  logic [RW-1:0]       prev_rem_im,
  input  logic [W:0]          prev_q_re,
  input  logic [W:0]          prev_q_im,
  output logic                valid,
  output cau_pkg::ctl_t       ctl,
  output logic signed [W-1:0] res_re,
  output logic signed [W-1:0] res_im,
  output logic [RW-1:0]       den,
  output logic [RW-1:0]       rem_re,
  output logic [RW-1:0]       rem_im,
  output logic [W:0]          q_re,
  output logic [W:0]          q_im
);

  logic          ge_re, ge_im;
  logic [RW-1:0] r_re, r_im;

  assign ge_re = prev_rem_re >= prev_den;
  assign ge_im = prev_rem_im >= prev_den;
  assign r_re  = ge_re ? prev_rem_re - prev_den : prev_rem_re;
  assign r_im  = ge_im ? prev_rem_im - prev_den : prev_rem_im;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (adv) valid <= prev_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl    <= prev_ctl;
      res_re <= prev_res_re;
      res_im <= prev_res_im;
      den    <= prev_den;
      rem_re <= r_re << 1;
      rem_im <= r_im << 1;
      q_re   <= {prev_q_re[W-1:0], ge_re};
      q_im   <= {prev_q_im[W-1:0], ge_im};
    end
  end

endmodule
